// ----- hw/rtl/triclinic_periodic_wrap_2d_assert.svh -----
// Assertion shorthands used by the wrap module.
// Every macro samples on clk and is disabled while rst is high.
`ifndef TRICLINIC_PERIODIC_WRAP_2D_ASSERT_SVH
`define TRICLINIC_PERIODIC_WRAP_2D_ASSERT_SVH

// Property holds at every edge.
`define TPW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TPW_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tpw_pkg.sv -----
package tpw_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  // Divider: width of the step counter over the 32 quotient bits per item
  localparam int unsigned DIV_CNT_W = 5;

  // Sequencer program addresses
  localparam int unsigned PC_W = 4;
  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_CHECK = 4'd1;
  localparam logic [PC_W-1:0] S_YDN   = 4'd2;
  localparam logic [PC_W-1:0] S_YUP   = 4'd3;
  localparam logic [PC_W-1:0] S_REL   = 4'd4;
  localparam logic [PC_W-1:0] S_MUL   = 4'd5;
  localparam logic [PC_W-1:0] S_DIVI  = 4'd6;
  localparam logic [PC_W-1:0] S_DIV   = 4'd7;
  localparam logic [PC_W-1:0] S_BND   = 4'd8;
  localparam logic [PC_W-1:0] S_XDN   = 4'd9;
  localparam logic [PC_W-1:0] S_XUP   = 4'd10;
  localparam logic [PC_W-1:0] S_EMIT  = 4'd11;
  localparam logic [PC_W-1:0] S_DONE  = 4'd12;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_YDN,
    OP_YUP,
    OP_REL,
    OP_MUL,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_BOUND,
    OP_XDN,
    OP_XUP,
    OP_EMIT
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_DEGEN,
    C_AGAIN,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  // One control word
  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Microcode ROM: if cond holds, jump to target, else fall through
  function automatic ctrl_t ucode(input logic [PC_W-1:0] step);
    ctrl_t w;
    case (step)
      S_IDLE:  w = '{op: OP_LOAD,    cond: C_NO_ITEM,  target: S_IDLE};
      S_CHECK: w = '{op: OP_NOP,     cond: C_DEGEN,    target: S_EMIT};
      S_YDN:   w = '{op: OP_YDN,     cond: C_AGAIN,    target: S_YDN};
      S_YUP:   w = '{op: OP_YUP,     cond: C_AGAIN,    target: S_YUP};
      S_REL:   w = '{op: OP_REL,     cond: C_NEVER,    target: S_IDLE};
      S_MUL:   w = '{op: OP_MUL,     cond: C_NEVER,    target: S_IDLE};
      S_DIVI:  w = '{op: OP_DIVINIT, cond: C_NEVER,    target: S_IDLE};
      S_DIV:   w = '{op: OP_DIVSTEP, cond: C_DIV_MORE, target: S_DIV};
      S_BND:   w = '{op: OP_BOUND,   cond: C_NEVER,    target: S_IDLE};
      S_XDN:   w = '{op: OP_XDN,     cond: C_AGAIN,    target: S_XDN};
      S_XUP:   w = '{op: OP_XUP,     cond: C_AGAIN,    target: S_XUP};
      S_EMIT:  w = '{op: OP_EMIT,    cond: C_OUT_BUSY, target: S_EMIT};
      S_DONE:  w = '{op: OP_NOP,     cond: C_ALWAYS,   target: S_IDLE};
      default: w = '{op: OP_NOP,     cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/tpw_if.sv -----
// Input point channel
interface tpw_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

// Result channel
interface tpw_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] wrapped_x;
  logic signed [31:0] wrapped_y;
  logic [1:0]         status;
  modport source (output valid, wrapped_x, wrapped_y, status, input ready);
  modport sink   (input valid, wrapped_x, wrapped_y, status, output ready);
endinterface

// Configuration write channel
interface tpw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tpw_pkg::CFG_IDX_W-1:0]   index;
  logic [31:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/triclinic_periodic_wrap_2d.sv -----
// Wraps one signed Q16.16 point into a sheared periodic box, one item at a time.
// A small microcode program steps a shared datapath: the y wraps, a 32x32
// multiply, a radix-2 restoring divide for the tilt offset at the wrapped
// height, then the x wraps. A new point is taken only in the idle step,
// after the previous one has left the emit step. A degenerate box goes
// straight from its check step to the emit step. The result sits in an
// output register, and the next point is accepted while it waits; a result
// that is still waiting when the next one is ready holds the sequencer in
// its emit step. Wraps are capped at MAX_WRAPS per item (status 1); a box
// with zero or negative height or width passes the point through (status 2).
// Configuration writes are taken whenever out of reset and must only arrive
// while idle.
`include "triclinic_periodic_wrap_2d_assert.svh"

module triclinic_periodic_wrap_2d #(
  parameter int unsigned MAX_WRAPS = 64
) (
  input logic          clk,
  input logic          rst,
  tpw_cfg_if.sink      cfg,
  tpw_point_if.sink    point,
  tpw_result_if.source result
);

  localparam int unsigned CNT_W = $clog2(MAX_WRAPS + 1);
  localparam int unsigned ACC_W = 35 + $clog2(MAX_WRAPS + 1);
  localparam int unsigned EXT   = ACC_W - 32;

  localparam logic signed [ACC_W-1:0] SAT_HI = {{EXT{1'b0}}, 32'h7fff_ffff};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{EXT{1'b1}}, 32'h8000_0000};

  // Configuration registers
  logic signed [31:0] x_low, x_high, y_low, y_high, tilt;

  // Sequencer
  logic [tpw_pkg::PC_W-1:0] pc, pc_next;
  tpw_pkg::ctrl_t           ctrl;
  logic                     take;

  // Datapath state
  logic signed [ACC_W-1:0]       x_acc, y_acc;
  logic signed [32:0]            h_len, w_len;
  logic                          degen, hit;
  logic [CNT_W-1:0]              count;
  logic [31:0]                   rel, mag;
  logic                          neg;
  logic [63:0]                   prod;
  logic [31:0]                   rem, quo;
  logic [tpw_pkg::DIV_CNT_W-1:0] div_cnt;
  logic signed [33:0]            left_b, right_b;

  // Combinational helpers
  logic                    accept, out_busy, need, cap, go;
  logic signed [32:0]      h_cfg, w_cfg;
  logic signed [ACC_W-1:0] yhi_ext, ylo_ext, tilt_ext, h_ext, w_ext, left_ext, right_ext;
  logic signed [ACC_W-1:0] rel_diff;
  logic [31:0]             rel_next, tilt_mag;
  logic [32:0]             trial, trial_diff;
  logic                    ge;
  logic signed [32:0]      dx;
  logic signed [31:0]      sat_x, sat_y;

  assign cfg.ready   = !rst;
  assign point.ready = (pc == tpw_pkg::S_IDLE) && !rst;
  assign accept      = point.valid && point.ready;
  assign out_busy    = result.valid && !result.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low  <= 32'sd0;
      x_high <= 32'sd65536;
      y_low  <= 32'sd0;
      y_high <= 32'sd65536;
      tilt   <= 32'sd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        tpw_pkg::CFG_X_LOW:  x_low  <= cfg.data;
        tpw_pkg::CFG_X_HIGH: x_high <= cfg.data;
        tpw_pkg::CFG_Y_LOW:  y_low  <= cfg.data;
        tpw_pkg::CFG_Y_HIGH: y_high <= cfg.data;
        tpw_pkg::CFG_TILT:   tilt   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Box sizes and sign extensions to the accumulator width
  assign h_cfg     = {y_high[31], y_high} - {y_low[31], y_low};
  assign w_cfg     = {x_high[31], x_high} - {x_low[31], x_low};
  assign yhi_ext   = {{EXT{y_high[31]}}, y_high};
  assign ylo_ext   = {{EXT{y_low[31]}}, y_low};
  assign tilt_ext  = {{EXT{tilt[31]}}, tilt};
  assign h_ext     = {{(ACC_W-33){h_len[32]}}, h_len};
  assign w_ext     = {{(ACC_W-33){w_len[32]}}, w_len};
  assign left_ext  = {{(ACC_W-34){left_b[33]}}, left_b};
  assign right_ext = {{(ACC_W-34){right_b[33]}}, right_b};

  // Wrap test for the current loop step
  always_comb begin
    case (ctrl.op)
      tpw_pkg::OP_YDN: need = (y_acc > yhi_ext);
      tpw_pkg::OP_YUP: need = (y_acc < ylo_ext);
      tpw_pkg::OP_XDN: need = (x_acc > right_ext);
      tpw_pkg::OP_XUP: need = (x_acc < left_ext);
      default:         need = 1'b0;
    endcase
  end
  assign cap = (count >= CNT_W'(MAX_WRAPS));
  assign go  = !hit && need && !cap;

  // Clamped height above the lower bound
  assign rel_diff = y_acc - ylo_ext;
  always_comb begin
    if (rel_diff < 0) begin
      rel_next = 32'd0;
    end else if (rel_diff > h_ext) begin
      rel_next = h_len[31:0];
    end else begin
      rel_next = rel_diff[31:0];
    end
  end
  assign tilt_mag = tilt[31] ? (~tilt + 32'd1) : tilt;

  // Restoring divide step
  assign trial      = {rem, quo[31]};
  assign trial_diff = trial - {1'b0, h_len[31:0]};
  assign ge         = (trial >= {1'b0, h_len[31:0]});

  assign dx = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  // Output saturation
  assign sat_x = (x_acc > SAT_HI) ? SAT_HI[31:0] : (x_acc < SAT_LO) ? SAT_LO[31:0] : x_acc[31:0];
  assign sat_y = (y_acc > SAT_HI) ? SAT_HI[31:0] : (y_acc < SAT_LO) ? SAT_LO[31:0] : y_acc[31:0];

  // Control word and next step
  assign ctrl = tpw_pkg::ucode(pc);
  always_comb begin
    case (ctrl.cond)
      tpw_pkg::C_NEVER:    take = 1'b0;
      tpw_pkg::C_ALWAYS:   take = 1'b1;
      tpw_pkg::C_NO_ITEM:  take = !accept;
      tpw_pkg::C_DEGEN:    take = degen;
      tpw_pkg::C_AGAIN:    take = go;
      tpw_pkg::C_DIV_MORE: take = (div_cnt != {tpw_pkg::DIV_CNT_W{1'b1}});
      tpw_pkg::C_OUT_BUSY: take = out_busy;
      default:             take = 1'b0;
    endcase
    pc_next = take ? ctrl.target : pc + 1'b1;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= tpw_pkg::S_IDLE;
      count        <= '0;
      hit          <= 1'b0;
      degen        <= 1'b0;
      div_cnt      <= '0;
      result.valid <= 1'b0;
    end else begin
      pc <= pc_next;
      // new result replaces the one leaving in the same cycle
      if (ctrl.op == tpw_pkg::OP_EMIT && !out_busy) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (ctrl.op)
        tpw_pkg::OP_LOAD: begin
          if (accept) begin
            count <= '0;
            hit   <= 1'b0;
            degen <= (h_cfg <= 0) || (w_cfg <= 0);
          end
        end
        tpw_pkg::OP_YDN, tpw_pkg::OP_YUP, tpw_pkg::OP_XDN, tpw_pkg::OP_XUP: begin
          if (!hit && need) begin
            if (cap) begin
              hit <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        tpw_pkg::OP_DIVINIT: div_cnt <= '0;
        tpw_pkg::OP_DIVSTEP: div_cnt <= div_cnt + 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (ctrl.op)
      tpw_pkg::OP_LOAD: begin
        if (accept) begin
          x_acc <= {{EXT{point.point_x[31]}}, point.point_x};
          y_acc <= {{EXT{point.point_y[31]}}, point.point_y};
          h_len <= h_cfg;
          w_len <= w_cfg;
        end
      end
      tpw_pkg::OP_YDN: begin
        if (go) begin
          x_acc <= x_acc - tilt_ext;
          y_acc <= y_acc - h_ext;
        end
      end
      tpw_pkg::OP_YUP: begin
        if (go) begin
          x_acc <= x_acc + tilt_ext;
          y_acc <= y_acc + h_ext;
        end
      end
      tpw_pkg::OP_REL: begin
        rel <= rel_next;
        mag <= tilt_mag;
        neg <= tilt[31];
      end
      tpw_pkg::OP_MUL: prod <= 64'(rel) * 64'(mag);
      tpw_pkg::OP_DIVINIT: begin
        rem <= prod[63:32];
        quo <= prod[31:0];
      end
      tpw_pkg::OP_DIVSTEP: begin
        rem <= ge ? trial_diff[31:0] : trial[31:0];
        quo <= {quo[30:0], ge};
      end
      tpw_pkg::OP_BOUND: begin
        left_b  <= {{2{x_low[31]}}, x_low} + {dx[32], dx};
        right_b <= {{2{x_high[31]}}, x_high} + {dx[32], dx};
      end
      tpw_pkg::OP_XDN: begin
        if (go) begin
          x_acc <= x_acc - w_ext;
        end
      end
      tpw_pkg::OP_XUP: begin
        if (go) begin
          x_acc <= x_acc + w_ext;
        end
      end
      tpw_pkg::OP_EMIT: begin
        if (!out_busy) begin
          result.wrapped_x <= sat_x;
          result.wrapped_y <= sat_y;
          result.status    <= degen ? tpw_pkg::ST_DEGEN :
                              hit   ? tpw_pkg::ST_LIMIT : tpw_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  // Checks
  `TPW_ASSERT_ALWAYS(a_count_cap, count <= CNT_W'(MAX_WRAPS), "wrap count passed cap")
  `TPW_ASSERT_IMPLY(a_degen_no_wrap, degen && pc != tpw_pkg::S_IDLE, !hit && count == '0, "degenerate box wrapped")
  `TPW_ASSERT_IMPLY(a_result_src, $rose(result.valid), $past(pc) == tpw_pkg::S_EMIT, "result raised outside emit step")
  `TPW_ASSERT_IMPLY(a_div_done, pc == tpw_pkg::S_BND, div_cnt == '0, "bounds formed before divide finished")
  `TPW_ASSERT_NEXT(a_hit_freeze, hit && !accept, $stable(y_acc), "y moved after wrap limit")

endmodule
